[design/wsd_pkg.sv]
// Shared types and constants of the WebSocket frame deframer.
package wsd_pkg;

  localparam int unsigned LEN_WIDTH = 64;

  typedef logic [LEN_WIDTH-1:0] len_t;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_LEN     = 3'd1,
    PH_EXT     = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MASK   = 2'd1,
    ST_OPCODE = 2'd2
  } status_e;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [2:0] EXT16_LEFT = 3'd1;
  localparam logic [2:0] EXT64_LEFT = 3'd7;
  localparam logic [2:0] KEY_BYTES  = 3'd4;

  typedef struct packed {
    logic       vld;
    logic [7:0] data_byte;
    logic       has_data;
    logic [3:0] frame_opcode;
    logic       fin_bit;
    logic       frame_end;
    status_e    status;
  } res_t;

  function automatic logic opcode_known(input logic [3:0] op);
    return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN) ||
           (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
  endfunction

endpackage

[design/websocket_frame_deframer.sv]
// Top level of the WebSocket frame deframer.
// Usage:
//   Input channel: one received byte per request on rx_byte_i, with
//   in_valid_i / in_ready_o. Output channel: at most one result per byte
//   on out_valid_o / out_ready_i: an unmasked payload byte, an empty-frame
//   marker, or an error report (status_o). Other header bytes give no result.
//   cfg_we_i / cfg_wdata_i set the role (1 client, 0 server); write it
//   only while the block is idle.
// Output: each result is registered before it reaches out_valid_o.
// Throughput: one byte per cycle while the skid entry is free, set by the
//   single parse step between the input handshake and the result register.
// Reset: parser waits for the first header byte, role is server, no error.
//   After an error every byte is consumed with no result until reset.
// Stall: while the receiver holds out_ready_i low, one further result is
//   kept in a skid entry; in_ready_o then drops until it drains.
module websocket_frame_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic       has_data_o,
  output logic [3:0] frame_opcode_o,
  output logic       fin_bit_o,
  output logic       frame_end_o,
  output logic [1:0] status_o
);

  wsd_pkg::res_t res;
  wsd_pkg::res_t out;
  logic          accept;

  assign accept = in_valid_i && in_ready_o;

  wsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .res_o       (res)
  );

  wsd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out)
  );

  assign data_byte_o    = out.data_byte;
  assign has_data_o     = out.has_data;
  assign frame_opcode_o = out.frame_opcode;
  assign fin_bit_o      = out.fin_bit;
  assign frame_end_o    = out.frame_end;
  assign status_o       = out.status;

endmodule

[design/wsd_parser.sv]
// Frame header parser, payload unmasking and role register.
module wsd_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          accept_i,
  input  logic [7:0]    rx_byte_i,
  output wsd_pkg::res_t res_o
);

  wsd_pkg::phase_e phase_q, phase_d;
  logic [2:0]      ext_q, ext_d;
  wsd_pkg::len_t   len_q, len_d;
  logic            ovf_q, ovf_d;
  logic [31:0]     key_q, key_d;
  logic [2:0]      kleft_q, kleft_d;
  logic [1:0]      pp_q, pp_d;
  logic [3:0]      op_q, op_d;
  logic            fin_q, fin_d;
  logic            masked_q, masked_d;
  logic            err_q, err_d;
  logic            is_client_q;
  logic            done_len, done_hdr;
  logic [7:0]      key_byte;
  wsd_pkg::res_t   res;

  // key byte 0 sits in bits 31..24
  assign key_byte = 8'(key_q >> {~pp_q, 3'b000});

  always_comb begin
    phase_d  = phase_q;
    ext_d    = ext_q;
    len_d    = len_q;
    ovf_d    = ovf_q;
    key_d    = key_q;
    kleft_d  = kleft_q;
    pp_d     = pp_q;
    op_d     = op_q;
    fin_d    = fin_q;
    masked_d = masked_q;
    err_d    = err_q;
    done_len = 1'b0;
    done_hdr = 1'b0;
    res      = '0;

    if (accept_i && !err_q) begin
      unique case (phase_q)
        wsd_pkg::PH_FIRST: begin
          fin_d = rx_byte_i[7];
          op_d  = rx_byte_i[3:0];
          if (wsd_pkg::opcode_known(rx_byte_i[3:0])) begin
            phase_d = wsd_pkg::PH_LEN;
          end else begin
            err_d      = 1'b1;
            res.vld    = 1'b1;
            res.frame_end = 1'b1;
            res.status = wsd_pkg::ST_OPCODE;
          end
        end
        wsd_pkg::PH_LEN: begin
          masked_d = rx_byte_i[7];
          if (rx_byte_i[7] == is_client_q) begin
            err_d      = 1'b1;
            phase_d    = wsd_pkg::PH_FIRST;
            res.vld    = 1'b1;
            res.frame_end = 1'b1;
            res.status = wsd_pkg::ST_MASK;
          end else begin
            ovf_d = 1'b0;
            len_d = '0;
            if (rx_byte_i[6:0] == wsd_pkg::LEN7_EXT16) begin
              ext_d   = wsd_pkg::EXT16_LEFT;
              phase_d = wsd_pkg::PH_EXT;
            end else if (rx_byte_i[6:0] == wsd_pkg::LEN7_EXT64) begin
              ext_d   = wsd_pkg::EXT64_LEFT;
              phase_d = wsd_pkg::PH_EXT;
            end else begin
              len_d    = wsd_pkg::len_t'(rx_byte_i[6:0]);
              done_len = 1'b1;
            end
          end
        end
        wsd_pkg::PH_EXT: begin
          // network order; bits pushed out of the top mean saturation later
          ovf_d = ovf_q | (len_q[wsd_pkg::LEN_WIDTH-1 -: 8] != 8'd0);
          len_d = {len_q[wsd_pkg::LEN_WIDTH-9:0], rx_byte_i};
          if (ext_q == 3'd0) begin
            done_len = 1'b1;
          end else begin
            ext_d = ext_q - 3'd1;
          end
        end
        wsd_pkg::PH_KEY: begin
          key_d   = {key_q[23:0], rx_byte_i};
          kleft_d = kleft_q - 3'd1;
          if (kleft_d == 3'd0) begin
            done_hdr = 1'b1;
          end
        end
        wsd_pkg::PH_PAYLOAD: begin
          pp_d          = pp_q + 2'd1;
          len_d         = len_q - wsd_pkg::len_t'(1);
          res.vld       = 1'b1;
          res.has_data  = 1'b1;
          res.data_byte = masked_q ? (rx_byte_i ^ key_byte) : rx_byte_i;
          if (len_d == '0) begin
            phase_d       = wsd_pkg::PH_FIRST;
            res.frame_end = 1'b1;
          end
        end
        default: begin
          phase_d = wsd_pkg::PH_FIRST;
        end
      endcase

      if (done_len) begin
        if (ovf_d) begin
          len_d = '1;
        end
        if (masked_d) begin
          kleft_d = wsd_pkg::KEY_BYTES;
          key_d   = '0;
          phase_d = wsd_pkg::PH_KEY;
        end else begin
          done_hdr = 1'b1;
        end
      end

      if (done_hdr) begin
        pp_d = 2'd0;
        if (len_d == '0) begin
          // empty frame: one marker with no data
          phase_d       = wsd_pkg::PH_FIRST;
          res.vld       = 1'b1;
          res.frame_end = 1'b1;
          res.status    = wsd_pkg::ST_OK;
        end else begin
          phase_d = wsd_pkg::PH_PAYLOAD;
        end
      end
    end

    res.frame_opcode = op_d;
    res.fin_bit      = fin_d;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= wsd_pkg::PH_FIRST;
      ext_q       <= '0;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      key_q       <= '0;
      kleft_q     <= '0;
      pp_q        <= '0;
      op_q        <= '0;
      fin_q       <= 1'b0;
      masked_q    <= 1'b0;
      err_q       <= 1'b0;
      is_client_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      ext_q    <= ext_d;
      len_q    <= len_d;
      ovf_q    <= ovf_d;
      key_q    <= key_d;
      kleft_q  <= kleft_d;
      pp_q     <= pp_d;
      op_q     <= op_d;
      fin_q    <= fin_d;
      masked_q <= masked_d;
      err_q    <= err_d;
      if (cfg_we_i) begin
        is_client_q <= cfg_wdata_i;
      end
    end
  end

endmodule

[design/wsd_out_buf.sv]
// Result register with one skid entry behind it.
module wsd_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wsd_pkg::res_t res_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output wsd_pkg::res_t out_o
);

  logic          out_vld_q, out_vld_d;
  logic          skid_vld_q, skid_vld_d;
  wsd_pkg::res_t out_q, out_d;
  wsd_pkg::res_t skid_q, skid_d;

  // requests are only taken while the skid entry is free
  assign in_ready_o  = !skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (!out_vld_q || out_ready_i) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_d      = skid_q;
        skid_vld_d = res_i.vld;
        skid_d     = res_i;
      end else begin
        out_vld_d = res_i.vld;
        out_d     = res_i;
      end
    end else if (res_i.vld) begin
      skid_vld_d = 1'b1;
      skid_d     = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

[design/wsd_checker.sv]
// Port-level checks of the WebSocket frame deframer, bound to the top level.
module wsd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] data_byte_i,
  input logic       has_data_i,
  input logic       frame_end_i,
  input logic [1:0] status_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(data_byte_i) &&
      $stable(status_i) && $stable(frame_end_i))
    else $error("result changed while stalled");

  a_nodata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !has_data_i |-> data_byte_i == 8'd0)
    else $error("data byte not zero without data");

  a_err_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != wsd_pkg::ST_OK) |-> frame_end_i && !has_data_i)
    else $error("error report not a closing marker");

  a_marker_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !has_data_i |-> frame_end_i)
    else $error("result without data does not end a frame");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .data_byte_i (data_byte_o),
  .has_data_i  (has_data_o),
  .frame_end_i (frame_end_o),
  .status_i    (status_o)
);
